/* design/fbpw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpw_pkg
// types, register indexes, constants and color quantizing for the
// framebuffer pixel writer
// ----------------------------------------------------------------------------
package fbpw_pkg;

  typedef enum logic [2:0] {
    MODE_TEXT     = 3'd0,
    MODE_RGB332   = 3'd1,
    MODE_RGB555   = 3'd2,
    MODE_RGB565   = 3'd3,
    MODE_RGB888   = 3'd4,
    MODE_XRGB8888 = 3'd5
  } mode_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int DIM_W      = 13;
  localparam int PITCH_W    = 16;
  localparam int ADDR_W     = 32;
  localparam int DATA_W     = 32;
  localparam int BYTES_W    = 3;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_CELL  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_BASE = 3'd4;

  localparam mode_t             RST_MODE   = MODE_XRGB8888;
  localparam logic [DIM_W-1:0]  RST_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0]  RST_HEIGHT = 13'd480;
  localparam logic [PITCH_W-1:0] RST_PITCH = 16'd2560;
  localparam logic [ADDR_W-1:0] RST_BASE   = 32'd0;

  localparam logic [7:0] GLYPH_BLOCK = 8'hDB;
  localparam logic [7:0] QUANT_HI    = 8'hAA;
  localparam logic [7:0] QUANT_LO    = 8'h55;

  localparam logic [3:0] RED_BRIGHT   = 4'hC;
  localparam logic [3:0] RED_DIM      = 4'h4;
  localparam logic [3:0] GREEN_BRIGHT = 4'hA;
  localparam logic [3:0] GREEN_DIM    = 4'h2;
  localparam logic [3:0] BLUE_BRIGHT  = 4'h9;
  localparam logic [3:0] BLUE_DIM     = 4'h1;

  localparam logic [BYTES_W-1:0] BYTES_1 = 3'd1;
  localparam logic [BYTES_W-1:0] BYTES_2 = 3'd2;
  localparam logic [BYTES_W-1:0] BYTES_3 = 3'd3;
  localparam logic [BYTES_W-1:0] BYTES_4 = 3'd4;

  function automatic logic [3:0] quant_chan(input logic [7:0] v, input logic [3:0] bright,
                                            input logic [3:0] dim);
    logic [3:0] q;
    if (v > QUANT_HI) begin
      q = bright;
    end else if (v > QUANT_LO) begin
      q = dim;
    end else begin
      q = 4'h0;
    end
    return q;
  endfunction

  // 16-color code of a 0xRRGGBB value
  function automatic logic [3:0] quantize(input logic [23:0] rgb);
    return quant_chan(rgb[23:16], RED_BRIGHT, RED_DIM)
         | quant_chan(rgb[15:8], GREEN_BRIGHT, GREEN_DIM)
         | quant_chan(rgb[7:0], BLUE_BRIGHT, BLUE_DIM);
  endfunction

endpackage

/* design/fbpw_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpw_in_if
// drawing request channel: one beat is a pixel or character cell write
// ----------------------------------------------------------------------------
interface fbpw_in_if #(
  parameter int COORD_BITS = 12
);
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  logic [31:0]           color;
  logic [23:0]           back_color;
  logic [7:0]            char_code;

  modport source (output valid, op, pos_x, pos_y, color, back_color, char_code,
                  input ready);
  modport sink   (input valid, op, pos_x, pos_y, color, back_color, char_code,
                  output ready);
endinterface

/* design/fbpw_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpw_out_if
// memory write channel: one beat is address, packed data and byte count
// ----------------------------------------------------------------------------
interface fbpw_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] wr_address;
  logic [31:0] wr_data;
  logic [2:0]  wr_bytes;

  modport source (output valid, wr_address, wr_data, wr_bytes, input ready);
  modport sink   (input valid, wr_address, wr_data, wr_bytes, output ready);
endinterface

/* design/framebuffer_pixel_writer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framebuffer_pixel_writer_top
// clips drawing requests and turns them into framebuffer memory writes
// ----------------------------------------------------------------------------
// The block takes one request per clock while the write side gives ready;
// the request is captured in an input register, then one row multiply (row
// times pitch, or times width in text mode), the address add and the color
// packing fill the result register that drives the write. Clipped requests,
// character cells in graphics modes and the unused mode codes leave no beat.
// Configuration is held in registers the user writes through the cfg port
// only while no request is in flight; the block does not enforce this.
module framebuffer_pixel_writer_top #(
  parameter int COORD_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  fbpw_in_if.sink                         in_bus,
  fbpw_out_if.source                      out_bus,
  input  logic                            cfg_we,
  input  logic [fbpw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbpw_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CMP_W  = (COORD_BITS > fbpw_pkg::DIM_W) ? COORD_BITS : fbpw_pkg::DIM_W;
  localparam int PROD_W = COORD_BITS + fbpw_pkg::PITCH_W;
  localparam int XOFF_W = COORD_BITS + 2;

  // configuration
  fbpw_pkg::mode_t                mode_r;
  logic [fbpw_pkg::DIM_W-1:0]     width_r;
  logic [fbpw_pkg::DIM_W-1:0]     height_r;
  logic [fbpw_pkg::PITCH_W-1:0]   pitch_r;
  logic [fbpw_pkg::ADDR_W-1:0]    base_r;

  // input stage
  logic                  a_valid_r;
  logic                  a_op_r;
  logic [COORD_BITS-1:0] a_x_r;
  logic [COORD_BITS-1:0] a_y_r;
  logic [31:0]           a_color_r;
  logic [23:0]           a_back_r;
  logic [7:0]            a_char_r;

  // result stage
  logic                           out_valid_r;
  logic                           out_valid_nxt;
  logic [fbpw_pkg::ADDR_W-1:0]    out_addr_r;
  logic [fbpw_pkg::DATA_W-1:0]    out_data_r;
  logic [fbpw_pkg::BYTES_W-1:0]   out_bytes_r;

  logic                           b_free;
  logic                           in_fire;
  logic                           keep;
  logic                           in_range;
  logic                           text_row;
  logic [fbpw_pkg::PITCH_W-1:0]   stride;
  logic [PROD_W-1:0]              row_prod;
  logic [fbpw_pkg::ADDR_W-1:0]    row_off;
  logic [XOFF_W-1:0]              x_off;
  logic [fbpw_pkg::ADDR_W-1:0]    addr_nxt;
  logic [fbpw_pkg::DATA_W-1:0]    data_nxt;
  logic [fbpw_pkg::BYTES_W-1:0]   bytes_nxt;
  logic [3:0]                     q_fore;
  logic [3:0]                     q_back;
  logic [7:0]                     attr;
  logic [7:0]                     glyph;

  assign b_free       = !out_valid_r || out_bus.ready;
  assign in_bus.ready = !a_valid_r || b_free;
  assign in_fire      = in_bus.valid && in_bus.ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= fbpw_pkg::RST_MODE;
      width_r  <= fbpw_pkg::RST_WIDTH;
      height_r <= fbpw_pkg::RST_HEIGHT;
      pitch_r  <= fbpw_pkg::RST_PITCH;
      base_r   <= fbpw_pkg::RST_BASE;
    end else if (cfg_we) begin
      case (cfg_index)
        fbpw_pkg::CFG_MODE:       mode_r   <= fbpw_pkg::mode_t'(cfg_data[2:0]);
        fbpw_pkg::CFG_WIDTH:      width_r  <= cfg_data[fbpw_pkg::DIM_W-1:0];
        fbpw_pkg::CFG_HEIGHT:     height_r <= cfg_data[fbpw_pkg::DIM_W-1:0];
        fbpw_pkg::CFG_PITCH:      pitch_r  <= cfg_data[fbpw_pkg::PITCH_W-1:0];
        fbpw_pkg::CFG_FRAME_BASE: base_r   <= cfg_data[fbpw_pkg::ADDR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      a_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_op_r    <= in_bus.op;
      a_x_r     <= in_bus.pos_x;
      a_y_r     <= in_bus.pos_y;
      a_color_r <= in_bus.color;
      a_back_r  <= in_bus.back_color;
      a_char_r  <= in_bus.char_code;
    end
  end

  // clip, pack and address
  always_comb begin
    in_range = (CMP_W'(a_x_r) < CMP_W'(width_r)) && (CMP_W'(a_y_r) < CMP_W'(height_r));
    q_fore   = fbpw_pkg::quantize(a_color_r[23:0]);
    q_back   = fbpw_pkg::quantize(a_back_r);
    if (a_op_r == fbpw_pkg::OP_CELL) begin
      attr  = {1'b0, q_back[2:0], q_fore};
      glyph = a_char_r;
    end else begin
      attr  = {4'h0, q_fore};
      glyph = fbpw_pkg::GLYPH_BLOCK;
    end

    keep      = 1'b0;
    text_row  = 1'b0;
    stride    = pitch_r;
    x_off     = XOFF_W'(a_x_r);
    data_nxt  = '0;
    bytes_nxt = fbpw_pkg::BYTES_4;
    case (mode_r)
      fbpw_pkg::MODE_TEXT: begin
        keep      = in_range;
        text_row  = 1'b1;
        stride    = fbpw_pkg::PITCH_W'(width_r);
        x_off     = {1'b0, a_x_r, 1'b0};
        data_nxt  = {16'h0000, attr, glyph};
        bytes_nxt = fbpw_pkg::BYTES_2;
      end
      fbpw_pkg::MODE_RGB332: begin
        keep      = in_range && (a_op_r == fbpw_pkg::OP_PIXEL);
        data_nxt  = {24'h0, a_color_r[23:21], a_color_r[15:13], a_color_r[7:6]};
        bytes_nxt = fbpw_pkg::BYTES_1;
      end
      fbpw_pkg::MODE_RGB555: begin
        keep      = in_range && (a_op_r == fbpw_pkg::OP_PIXEL);
        x_off     = {1'b0, a_x_r, 1'b0};
        data_nxt  = {17'h0, a_color_r[23:19], a_color_r[15:11], a_color_r[7:3]};
        bytes_nxt = fbpw_pkg::BYTES_2;
      end
      fbpw_pkg::MODE_RGB565: begin
        keep      = in_range && (a_op_r == fbpw_pkg::OP_PIXEL);
        x_off     = {1'b0, a_x_r, 1'b0};
        data_nxt  = {16'h0, a_color_r[23:19], a_color_r[15:10], a_color_r[7:3]};
        bytes_nxt = fbpw_pkg::BYTES_2;
      end
      fbpw_pkg::MODE_RGB888: begin
        keep      = in_range && (a_op_r == fbpw_pkg::OP_PIXEL);
        x_off     = {2'b00, a_x_r} + {1'b0, a_x_r, 1'b0};
        data_nxt  = {8'h00, a_color_r[23:0]};
        bytes_nxt = fbpw_pkg::BYTES_3;
      end
      fbpw_pkg::MODE_XRGB8888: begin
        keep      = in_range && (a_op_r == fbpw_pkg::OP_PIXEL);
        x_off     = {a_x_r, 2'b00};
        data_nxt  = a_color_r;
        bytes_nxt = fbpw_pkg::BYTES_4;
      end
      default: begin
        keep = 1'b0;
      end
    endcase

    row_prod = PROD_W'(a_y_r) * PROD_W'(stride);
    if (text_row) begin
      row_off = {fbpw_pkg::ADDR_W'(row_prod)} << 1;
    end else begin
      row_off = fbpw_pkg::ADDR_W'(row_prod);
    end
    addr_nxt = base_r + row_off + fbpw_pkg::ADDR_W'(x_off);
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (b_free) begin
      out_valid_nxt = a_valid_r && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b_free && a_valid_r && keep) begin
      out_addr_r  <= addr_nxt;
      out_data_r  <= data_nxt;
      out_bytes_r <= bytes_nxt;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.wr_address = out_addr_r;
  assign out_bus.wr_data    = out_data_r;
  assign out_bus.wr_bytes   = out_bytes_r;

  // checks
  a_bytes_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_bytes_r == fbpw_pkg::BYTES_1 || out_bytes_r == fbpw_pkg::BYTES_2 ||
                     out_bytes_r == fbpw_pkg::BYTES_3 || out_bytes_r == fbpw_pkg::BYTES_4))
    else $error("write beat with illegal byte count");

  a_beat_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(a_valid_r))
    else $error("write beat appeared without a captured request");

  a_text_two_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && mode_r == fbpw_pkg::MODE_TEXT) |-> (out_bytes_r == fbpw_pkg::BYTES_2))
    else $error("text cell write not two bytes");

  a_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bytes_r == fbpw_pkg::BYTES_2) |-> (out_data_r[31:16] == 16'h0000))
    else $error("bytes above the count are not zero");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !a_valid_r |-> in_bus.ready)
    else $error("empty input stage refused a beat");

endmodule

/* sim/tb_framebuffer_pixel_writer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_framebuffer_pixel_writer_top
// Self-checking bench for the framebuffer pixel writer. Drawing requests are
// sent with random gaps in most phases. Each accepted request is run through
// a local model of clipping, addressing and color packing. Write beats are
// checked in order against the model's queue. The bench steps through
// every display mode, zero and full-size clip windows, and address wrap.
// ----------------------------------------------------------------------------
module tb_framebuffer_pixel_writer_top;

  typedef struct {
    logic [31:0] wr_address;
    logic [31:0] wr_data;
    logic [2:0]  wr_bytes;
  } mem_write_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [fbpw_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [fbpw_pkg::CFG_DATA_W-1:0] cfg_data;

  fbpw_in_if #(.COORD_BITS(12)) in_bus();
  fbpw_out_if                   out_bus();

  framebuffer_pixel_writer_top #(.COORD_BITS(12)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // local copy of the display registers
  logic [2:0]                   fb_mode   = fbpw_pkg::MODE_XRGB8888;
  logic [fbpw_pkg::DIM_W-1:0]   fb_width  = fbpw_pkg::RST_WIDTH;
  logic [fbpw_pkg::DIM_W-1:0]   fb_height = fbpw_pkg::RST_HEIGHT;
  logic [fbpw_pkg::PITCH_W-1:0] fb_pitch  = fbpw_pkg::RST_PITCH;
  logic [31:0]                  fb_base   = fbpw_pkg::RST_BASE;

  mem_write_t pending_writes[$];
  int requests_sent  = 0;
  int writes_checked = 0;
  int reg_writes     = 0;
  int error_count    = 0;
  bit no_gaps        = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endtask

  function automatic logic [3:0] tint_code(input logic [23:0] rgb);
    logic [3:0] code;
    code = 4'h0;
    if (rgb[23:16] > 8'hAA) code |= fbpw_pkg::RED_BRIGHT;
    else if (rgb[23:16] > 8'h55) code |= fbpw_pkg::RED_DIM;
    if (rgb[15:8] > 8'hAA) code |= fbpw_pkg::GREEN_BRIGHT;
    else if (rgb[15:8] > 8'h55) code |= fbpw_pkg::GREEN_DIM;
    if (rgb[7:0] > 8'hAA) code |= fbpw_pkg::BLUE_BRIGHT;
    else if (rgb[7:0] > 8'h55) code |= fbpw_pkg::BLUE_DIM;
    return code;
  endfunction

  // memory write caused by one drawing request, if any
  function automatic bit predict_mem_write(input logic op, input logic [11:0] x,
                                           input logic [11:0] y, input logic [31:0] col,
                                           input logic [23:0] back, input logic [7:0] ch,
                                           output mem_write_t w);
    logic [31:0] xw;
    logic [31:0] yw;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [3:0]  fg;
    logic [3:0]  bg;
    xw = {20'd0, x};
    yw = {20'd0, y};
    r = col[23:16];
    g = col[15:8];
    b = col[7:0];
    w.wr_address = '0;
    w.wr_data = '0;
    w.wr_bytes = '0;
    if (fb_mode > fbpw_pkg::MODE_XRGB8888) return 1'b0;
    if (xw >= {19'd0, fb_width} || yw >= {19'd0, fb_height}) return 1'b0;
    if (fb_mode == fbpw_pkg::MODE_TEXT) begin
      fg = tint_code(col[23:0]);
      bg = tint_code(back);
      if (op == fbpw_pkg::OP_CELL) begin
        w.wr_data = {16'd0, 1'b0, bg[2:0], fg, ch};
      end else begin
        w.wr_data = {16'd0, 4'd0, fg, fbpw_pkg::GLYPH_BLOCK};
      end
      w.wr_bytes = fbpw_pkg::BYTES_2;
      w.wr_address = fb_base + (yw * {19'd0, fb_width} + xw) * 32'd2;
      return 1'b1;
    end
    if (op == fbpw_pkg::OP_CELL) return 1'b0;
    case (fb_mode)
      fbpw_pkg::MODE_RGB332: begin
        w.wr_data = {24'd0, r[7:5], g[7:5], b[7:6]};
        w.wr_bytes = fbpw_pkg::BYTES_1;
      end
      fbpw_pkg::MODE_RGB555: begin
        w.wr_data = {17'd0, r[7:3], g[7:3], b[7:3]};
        w.wr_bytes = fbpw_pkg::BYTES_2;
      end
      fbpw_pkg::MODE_RGB565: begin
        w.wr_data = {16'd0, r[7:3], g[7:2], b[7:3]};
        w.wr_bytes = fbpw_pkg::BYTES_2;
      end
      fbpw_pkg::MODE_RGB888: begin
        w.wr_data = {8'd0, col[23:0]};
        w.wr_bytes = fbpw_pkg::BYTES_3;
      end
      default: begin
        w.wr_data = col;
        w.wr_bytes = fbpw_pkg::BYTES_4;
      end
    endcase
    w.wr_address = fb_base + yw * {16'd0, fb_pitch} + xw * {29'd0, w.wr_bytes};
    return 1'b1;
  endfunction

  // one request beat, entered and left at a rising edge
  task automatic send_request(input logic op, input logic [11:0] x, input logic [11:0] y,
                              input logic [31:0] col, input logic [23:0] back,
                              input logic [7:0] ch);
    int gap;
    mem_write_t w;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.op         <= op;
    in_bus.pos_x      <= x;
    in_bus.pos_y      <= y;
    in_bus.color      <= col;
    in_bus.back_color <= back;
    in_bus.char_code  <= ch;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    requests_sent++;
    if (predict_mem_write(op, x, y, col, back, ch, w)) pending_writes.push_back(w);
  endtask

  // stop sending and let every outstanding write come out
  task automatic drain_requests();
    int guard;
    guard = 0;
    in_bus.valid <= 1'b0;
    while (pending_writes.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [fbpw_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    reg_writes++;
    case (idx)
      fbpw_pkg::CFG_MODE:       fb_mode = value[2:0];
      fbpw_pkg::CFG_WIDTH:      fb_width = value[fbpw_pkg::DIM_W-1:0];
      fbpw_pkg::CFG_HEIGHT:     fb_height = value[fbpw_pkg::DIM_W-1:0];
      fbpw_pkg::CFG_PITCH:      fb_pitch = value[fbpw_pkg::PITCH_W-1:0];
      fbpw_pkg::CFG_FRAME_BASE: fb_base = value;
      default: ;
    endcase
  endtask

  task automatic apply_setup(input logic [2:0] m, input int wd, input int ht,
                             input logic [15:0] pitch, input logic [31:0] base);
    drain_requests();
    write_reg(fbpw_pkg::CFG_MODE, {29'd0, m});
    write_reg(fbpw_pkg::CFG_WIDTH, 32'(wd));
    write_reg(fbpw_pkg::CFG_HEIGHT, 32'(ht));
    write_reg(fbpw_pkg::CFG_PITCH, {16'd0, pitch});
    write_reg(fbpw_pkg::CFG_FRAME_BASE, base);
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_dim();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 1;
    if (r == 1) return 4096;
    if (r == 2) return $urandom_range(1, 16);
    return $urandom_range(1, 4096);
  endfunction

  function automatic logic [11:0] pick_coord(input int limit);
    int lim;
    int r;
    lim = (limit > 4096) ? 4096 : limit;
    r = $urandom_range(0, 19);
    if (lim == 0 || r == 2 || r == 3) return 12'($urandom_range(0, 4095));
    if (r == 0) return 12'(lim - 1);
    if (r == 1) return (limit > 4095) ? 12'hFFF : 12'(limit);
    return 12'($urandom_range(0, lim - 1));
  endfunction

  // channel values biased toward the quantizer thresholds
  function automatic logic [7:0] pick_chan();
    case ($urandom_range(0, 7))
      0: return 8'h55;
      1: return 8'h56;
      2: return 8'hAA;
      3: return 8'hAB;
      4: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // out-of-reset registers: 32bpp, 640x480
  task automatic test_reset_values();
    send_request(fbpw_pkg::OP_PIXEL, 12'd0, 12'd0, 32'hFFFF_FFFF, 24'h0, 8'h0);
    send_request(fbpw_pkg::OP_PIXEL, 12'd639, 12'd479, 32'h0000_0000, 24'hFFFFFF, 8'hFF);
    send_request(fbpw_pkg::OP_PIXEL, 12'd640, 12'd0, 32'h1234_5678, 24'h0, 8'h0);
    send_request(fbpw_pkg::OP_PIXEL, 12'd0, 12'd480, 32'h1234_5678, 24'h0, 8'h0);
    send_request(fbpw_pkg::OP_CELL, 12'd10, 12'd10, 32'hFFFF_FFFF, 24'hFFFFFF, 8'h41);
  endtask

  task automatic test_graphics_formats();
    logic [2:0] m;
    for (int k = 1; k <= 4; k++) begin
      m = 3'(k);
      apply_setup(m, 4096, 4096, 16'hFFFF, 32'hFFFF_FFF0);
      send_request(fbpw_pkg::OP_PIXEL, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF, 24'h0, 8'h0);
      send_request(fbpw_pkg::OP_PIXEL, 12'd0, 12'd0, 32'h00A5_5A3C, 24'h0, 8'h0);
    end
  endtask

  task automatic test_text_cells();
    apply_setup(fbpw_pkg::MODE_TEXT, 4096, 4096, 16'd0, 32'h8000_0000);
    send_request(fbpw_pkg::OP_CELL, 12'hFFF, 12'hFFF, 32'h0056_5656, 24'hABABAB, 8'h41);
    send_request(fbpw_pkg::OP_CELL, 12'd0, 12'd0, 32'h00AA_AAAA, 24'h555555, 8'hFF);
    send_request(fbpw_pkg::OP_PIXEL, 12'd100, 12'd7, 32'hFFAB_AB00, 24'hFFFFFF, 8'h00);
    send_request(fbpw_pkg::OP_PIXEL, 12'hFFF, 12'd0, 32'h0000_0000, 24'h000000, 8'h20);
    apply_setup(fbpw_pkg::MODE_TEXT, 80, 25, 16'd160, 32'h000B_8000);
    send_request(fbpw_pkg::OP_CELL, 12'd80, 12'd0, 32'h00FF_0000, 24'h00FF00, 8'h42);
    send_request(fbpw_pkg::OP_CELL, 12'd79, 12'd24, 32'h00FF_0000, 24'h00FF00, 8'h42);
  endtask

  task automatic test_zero_window();
    apply_setup(fbpw_pkg::MODE_RGB565, 0, 480, 16'd1280, 32'd0);
    send_request(fbpw_pkg::OP_PIXEL, 12'd0, 12'd0, 32'h00FF_FFFF, 24'h0, 8'h0);
    apply_setup(fbpw_pkg::MODE_RGB565, 640, 0, 16'd1280, 32'd0);
    send_request(fbpw_pkg::OP_PIXEL, 12'd0, 12'd0, 32'h00FF_FFFF, 24'h0, 8'h0);
  endtask

  task automatic test_unused_modes();
    apply_setup(3'd6, 640, 480, 16'd2560, 32'd0);
    send_request(fbpw_pkg::OP_PIXEL, 12'd1, 12'd1, 32'hFFFF_FFFF, 24'h0, 8'h0);
    apply_setup(3'd7, 640, 480, 16'd2560, 32'd0);
    send_request(fbpw_pkg::OP_CELL, 12'd1, 12'd1, 32'hFFFF_FFFF, 24'hFFFFFF, 8'h41);
  endtask

  task automatic test_random_phases();
    logic [2:0]  m;
    int          wd;
    int          ht;
    logic [15:0] pitch;
    logic [31:0] base;
    logic        op;
    int          r;
    for (int p = 0; p < 11; p++) begin
      m = (p < 6) ? 3'(p) : 3'($urandom_range(0, 5));
      wd = (p == 0) ? 4096 : pick_dim();
      ht = (p == 0) ? 4096 : pick_dim();
      r = $urandom_range(0, 3);
      pitch = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
      r = $urandom_range(0, 3);
      base = (r == 0) ? 32'd0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
      no_gaps = (p % 4 == 3);
      apply_setup(m, wd, ht, pitch, base);
      for (int i = 0; i < 50; i++) begin
        if (m == fbpw_pkg::MODE_TEXT) op = 1'($urandom_range(0, 1));
        else op = ($urandom_range(0, 9) == 0) ? fbpw_pkg::OP_CELL : fbpw_pkg::OP_PIXEL;
        send_request(op, pick_coord(wd), pick_coord(ht),
                     {8'($urandom_range(0, 255)), pick_chan(), pick_chan(), pick_chan()},
                     {pick_chan(), pick_chan(), pick_chan()}, 8'($urandom_range(0, 255)));
      end
    end
    no_gaps = 0;
  endtask

  // write beat checker
  always @(posedge clk) begin : check_writes
    mem_write_t want;
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      writes_checked++;
      if (pending_writes.size() == 0) begin
        flag_error($sformatf("unexpected write: address %h data %h bytes %0d",
                             out_bus.wr_address, out_bus.wr_data, out_bus.wr_bytes));
      end else begin
        want = pending_writes.pop_front();
        if (out_bus.wr_address !== want.wr_address)
          flag_error($sformatf("wr_address expected %h actual %h",
                               want.wr_address, out_bus.wr_address));
        if (out_bus.wr_data !== want.wr_data)
          flag_error($sformatf("wr_data expected %h actual %h",
                               want.wr_data, out_bus.wr_data));
        if (out_bus.wr_bytes !== want.wr_bytes)
          flag_error($sformatf("wr_bytes expected %0d actual %0d",
                               want.wr_bytes, out_bus.wr_bytes));
      end
    end
  end

  // write side back-pressure
  initial begin
    int stall;
    out_bus.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!(out_bus.valid === 1'b1 && out_bus.ready === 1'b1));
    end
  end

  initial begin
    #5ms;
    $display("timeout waiting for write beats");
    $display("framebuffer_pixel_writer_top: mismatch");
    $finish;
  end

  initial begin
    mem_write_t w;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_data          <= '0;
    in_bus.valid      <= 1'b0;
    in_bus.op         <= fbpw_pkg::OP_PIXEL;
    in_bus.pos_x      <= '0;
    in_bus.pos_y      <= '0;
    in_bus.color      <= '0;
    in_bus.back_color <= '0;
    in_bus.char_code  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_graphics_formats();
    test_text_cells();
    test_zero_window();
    test_unused_modes();
    test_random_phases();

    drain_requests();
    repeat (8) @(posedge clk);
    while (pending_writes.size() != 0) begin
      w = pending_writes.pop_front();
      flag_error($sformatf("missing write: address %h data %h bytes %0d",
                           w.wr_address, w.wr_data, w.wr_bytes));
    end
    $display("%0d requests, %0d register writes, %0d write beats checked, %0d errors",
             requests_sent, reg_writes, writes_checked, error_count);
    $display("covered text and all pixel formats, clip edges, zero windows, unused modes");
    if (error_count == 0) begin
      $display("framebuffer_pixel_writer_top: match");
    end else begin
      $display("framebuffer_pixel_writer_top: mismatch");
    end
    $finish;
  end

endmodule

/* framebuffer_pixel_writer_top.f */
design/fbpw_pkg.sv
design/fbpw_in_if.sv
design/fbpw_out_if.sv
design/framebuffer_pixel_writer_top.sv
sim/tb_framebuffer_pixel_writer_top.sv
